/* hdl/ibq_pkg.sv */
// Package for the indexed bucket minimum queue.
// Holds sizes, field structs, codes and the sequencer state and op types.
// No dependencies.
`default_nettype none
package ibq_pkg;

  localparam int NUM_ELEMENTS = 256;
  localparam int NUM_KEYS     = 64;

  localparam int EW = $clog2(NUM_ELEMENTS);      // element id / slot bits
  localparam int KW = $clog2(NUM_KEYS);          // bin index bits
  localparam int LW = $clog2(NUM_ELEMENTS + 1);  // bin length / count bits
  localparam int AW = KW + 1;                    // allocated bins / scan index bits

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] element;
    logic [5:0] key;
  } ibq_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       member;
    logic       next_valid;
    logic [7:0] next_element;
    logic [7:0] top_element;
    logic [5:0] top_key;
    logic       empty_res;
    logic [8:0] count;
  } ibq_res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_POS_D, S_DEL_LEN, S_DEL_MOVE, S_MIN_SCAN,
    S_POS_Q, S_Q_LEN, S_Q_SCAN, S_Q_SLOT, S_TOP, S_RESP
  } ibq_state_e;

  typedef enum logic [3:0] {
    OP_IDLE, OP_ACCEPT, OP_INS, OP_POS, OP_DEL_LEN, OP_DEL_MOVE, OP_MIN_STEP,
    OP_Q_LEN, OP_Q_SCAN, OP_Q_SLOT, OP_TOP, OP_RESP
  } ibq_op_e;

  typedef struct packed {
    logic [1:0] in_cmd;       // command of the item on the input
    logic       in_go;        // item on the input will modify or search
    logic       count_one;    // one element stored before the delete
    logic       min_done;     // minimum pointer rests on a nonempty bin or the last bin
    logic       succ_in_bin;  // successor lies in the same bin
    logic       scan_hit;     // scan index points at a nonempty bin
    logic       scan_end;     // scan index past the allocated bins
  } ibq_status_t;

endpackage
`default_nettype wire

/* hdl/ibq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ibq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/ibq_ctrl.sv */
// Sequencer for the indexed bucket minimum queue.
// Depends on ibq_pkg; issues one op a cycle to ibq_dp.
`default_nettype none
module ibq_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire ibq_pkg::ibq_status_t st_i,
  output ibq_pkg::ibq_op_e          op_o,
  output logic                      busy_o
);

  ibq_pkg::ibq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibq_pkg::S_IDLE: begin
        if (start_i) begin
          if (!st_i.in_go) begin
            state_d = ibq_pkg::S_TOP;
          end else if (st_i.in_cmd == ibq_pkg::CMD_INSERT) begin
            state_d = ibq_pkg::S_INS;
          end else if (st_i.in_cmd == ibq_pkg::CMD_DELETE) begin
            state_d = ibq_pkg::S_POS_D;
          end else begin
            state_d = ibq_pkg::S_POS_Q;
          end
        end
      end
      ibq_pkg::S_INS:     state_d = ibq_pkg::S_TOP;
      ibq_pkg::S_POS_D:   state_d = ibq_pkg::S_DEL_LEN;
      ibq_pkg::S_DEL_LEN: state_d = ibq_pkg::S_DEL_MOVE;
      ibq_pkg::S_DEL_MOVE: begin
        state_d = st_i.count_one ? ibq_pkg::S_TOP : ibq_pkg::S_MIN_SCAN;
      end
      ibq_pkg::S_MIN_SCAN: begin
        if (st_i.min_done) begin
          state_d = ibq_pkg::S_TOP;
        end
      end
      ibq_pkg::S_POS_Q: state_d = ibq_pkg::S_Q_LEN;
      ibq_pkg::S_Q_LEN: begin
        state_d = st_i.succ_in_bin ? ibq_pkg::S_Q_SLOT : ibq_pkg::S_Q_SCAN;
      end
      ibq_pkg::S_Q_SCAN: begin
        if (st_i.scan_end) begin
          state_d = ibq_pkg::S_TOP;
        end else if (st_i.scan_hit) begin
          state_d = ibq_pkg::S_Q_SLOT;
        end
      end
      ibq_pkg::S_Q_SLOT: state_d = ibq_pkg::S_TOP;
      ibq_pkg::S_TOP:    state_d = ibq_pkg::S_RESP;
      ibq_pkg::S_RESP:   state_d = ibq_pkg::S_IDLE;
      default:           state_d = ibq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != ibq_pkg::S_IDLE);
    unique case (state_q)
      ibq_pkg::S_IDLE:     op_o = start_i ? ibq_pkg::OP_ACCEPT : ibq_pkg::OP_IDLE;
      ibq_pkg::S_INS:      op_o = ibq_pkg::OP_INS;
      ibq_pkg::S_POS_D:    op_o = ibq_pkg::OP_POS;
      ibq_pkg::S_DEL_LEN:  op_o = ibq_pkg::OP_DEL_LEN;
      ibq_pkg::S_DEL_MOVE: op_o = ibq_pkg::OP_DEL_MOVE;
      ibq_pkg::S_MIN_SCAN: op_o = ibq_pkg::OP_MIN_STEP;
      ibq_pkg::S_POS_Q:    op_o = ibq_pkg::OP_POS;
      ibq_pkg::S_Q_LEN:    op_o = ibq_pkg::OP_Q_LEN;
      ibq_pkg::S_Q_SCAN:   op_o = ibq_pkg::OP_Q_SCAN;
      ibq_pkg::S_Q_SLOT:   op_o = ibq_pkg::OP_Q_SLOT;
      ibq_pkg::S_TOP:      op_o = ibq_pkg::OP_TOP;
      ibq_pkg::S_RESP:     op_o = ibq_pkg::OP_RESP;
      default:             op_o = ibq_pkg::OP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/ibq_dp.sv */
// Datapath for the indexed bucket minimum queue: bin, position and length
// RAMs, presence and occupancy bits, pointers and the result register.
// Depends on ibq_pkg and ibq_ram.
`default_nettype none
module ibq_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ibq_pkg::ibq_op_e  op_i,
  input  wire ibq_pkg::ibq_req_t req_i,
  output ibq_pkg::ibq_status_t   st_o,
  output ibq_pkg::ibq_res_t      res_o,
  output logic                   done_o
);

  localparam int EW = ibq_pkg::EW;
  localparam int KW = ibq_pkg::KW;
  localparam int LW = ibq_pkg::LW;
  localparam int AW = ibq_pkg::AW;
  localparam int NE = ibq_pkg::NUM_ELEMENTS;
  localparam int NK = ibq_pkg::NUM_KEYS;

  // Control state
  logic [NE-1:0] present_q, present_d;
  logic [NK-1:0] nonempty_q, nonempty_d;
  logic [AW-1:0] alloc_q, alloc_d;
  logic [KW-1:0] min_q, min_d;
  logic [LW-1:0] count_q, count_d;
  logic          strobe_q;

  // Per-item payload
  logic [EW-1:0] elem_q;
  logic [KW-1:0] key_q, b_q;
  logic [EW-1:0] s_q;
  logic [AW-1:0] idx_q;
  logic [1:0]    status_q;
  logic          nvalid_q;
  logic [EW-1:0] nelem_q;
  ibq_pkg::ibq_res_t res_q;

  // RAM ports
  logic                 sl_we, ps_we, bl_we;
  logic [KW+EW-1:0]     sl_waddr, sl_raddr, ps_wdata, ps_rdata;
  logic [EW-1:0]        sl_wdata, sl_rdata, ps_waddr, ps_raddr;
  logic [KW-1:0]        bl_waddr, bl_raddr;
  logic [LW-1:0]        bl_wdata, bl_rdata;

  ibq_ram #(.WIDTH(EW), .DEPTH(NK * NE)) u_slots (
    .clk_i, .we_i(sl_we), .waddr_i(sl_waddr), .wdata_i(sl_wdata),
    .raddr_i(sl_raddr), .rdata_o(sl_rdata)
  );
  ibq_ram #(.WIDTH(KW + EW), .DEPTH(NE)) u_pos (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(ps_wdata),
    .raddr_i(ps_raddr), .rdata_o(ps_rdata)
  );
  ibq_ram #(.WIDTH(LW), .DEPTH(NK)) u_len (
    .clk_i, .we_i(bl_we), .waddr_i(bl_waddr), .wdata_i(bl_wdata),
    .raddr_i(bl_raddr), .rdata_o(bl_rdata)
  );

  logic          in_range_bad, in_present;
  logic [LW-1:0] ins_len, del_last;
  logic [LW-1:0] count_dec;

  assign in_range_bad = ({1'b0, req_i.key} >= AW'(NK)) ||
                        ({1'b0, req_i.element} >= (EW + 1)'(NE));
  assign in_present   = present_q[req_i.element];
  assign ins_len      = nonempty_q[key_q] ? bl_rdata : '0;
  assign del_last     = bl_rdata - LW'(1);
  assign count_dec    = count_q - LW'(1);

  always_comb begin
    st_o.in_cmd      = req_i.command;
    unique case (req_i.command)
      ibq_pkg::CMD_INSERT: st_o.in_go = !in_range_bad && !in_present;
      ibq_pkg::CMD_DELETE,
      ibq_pkg::CMD_QUERY:  st_o.in_go = in_present;
      default:             st_o.in_go = 1'b0;
    endcase
    st_o.count_one   = (count_q == LW'(1));
    st_o.min_done    = !((AW'(min_q) < AW'(NK - 1)) && !nonempty_q[min_q]);
    st_o.succ_in_bin = ((LW'(s_q) + LW'(1)) < bl_rdata);
    st_o.scan_end    = !((idx_q < alloc_q) && (idx_q < AW'(NK)));
    st_o.scan_hit    = !st_o.scan_end && nonempty_q[idx_q[KW-1:0]];
  end

  // RAM addressing
  always_comb begin
    sl_we    = 1'b0;
    ps_we    = 1'b0;
    bl_we    = 1'b0;
    sl_waddr = {key_q, ins_len[EW-1:0]};
    sl_wdata = elem_q;
    ps_waddr = elem_q;
    ps_wdata = {key_q, ins_len[EW-1:0]};
    bl_waddr = key_q;
    bl_wdata = ins_len + LW'(1);
    ps_raddr = req_i.element;
    bl_raddr = req_i.key;
    sl_raddr = {min_q, EW'(0)};
    unique case (op_i)
      ibq_pkg::OP_INS: begin
        sl_we = 1'b1;
        ps_we = 1'b1;
        bl_we = 1'b1;
      end
      ibq_pkg::OP_POS:     bl_raddr = ps_rdata[KW+EW-1:EW];
      ibq_pkg::OP_DEL_LEN: begin
        // Hold the bin length on the read port for the move step
        sl_raddr = {b_q, del_last[EW-1:0]};
        bl_raddr = b_q;
      end
      ibq_pkg::OP_DEL_MOVE: begin
        // Move the last entry of the bin into the freed slot
        sl_we    = 1'b1;
        ps_we    = 1'b1;
        bl_we    = 1'b1;
        sl_waddr = {b_q, s_q};
        sl_wdata = sl_rdata;
        ps_waddr = sl_rdata;
        ps_wdata = {b_q, s_q};
        bl_waddr = b_q;
        bl_wdata = del_last;
      end
      ibq_pkg::OP_Q_LEN:  sl_raddr = {b_q, s_q + EW'(1)};
      ibq_pkg::OP_Q_SCAN: sl_raddr = {idx_q[KW-1:0], EW'(0)};
      default: ;
    endcase
  end

  // Control state update
  always_comb begin
    present_d  = present_q;
    nonempty_d = nonempty_q;
    alloc_d    = alloc_q;
    min_d      = min_q;
    count_d    = count_q;
    unique case (op_i)
      ibq_pkg::OP_INS: begin
        present_d[elem_q] = 1'b1;
        nonempty_d[key_q] = 1'b1;
        count_d           = count_q + LW'(1);
        if (alloc_q <= AW'(key_q)) begin
          alloc_d = AW'(key_q) + AW'(1);
        end
        if ((key_q < min_q) || (count_q == '0)) begin
          min_d = key_q;
        end
      end
      ibq_pkg::OP_DEL_MOVE: begin
        present_d[elem_q] = 1'b0;
        nonempty_d[b_q]   = (del_last != '0);
        count_d           = count_dec;
      end
      ibq_pkg::OP_MIN_STEP: begin
        if (!st_o.min_done) begin
          min_d = min_q + KW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= '0;
      nonempty_q <= '0;
      alloc_q    <= '0;
      min_q      <= '0;
      count_q    <= '0;
      strobe_q   <= 1'b0;
    end else begin
      present_q  <= present_d;
      nonempty_q <= nonempty_d;
      alloc_q    <= alloc_d;
      min_q      <= min_d;
      count_q    <= count_d;
      strobe_q   <= (op_i == ibq_pkg::OP_RESP);
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      ibq_pkg::OP_ACCEPT: begin
        elem_q   <= req_i.element;
        key_q    <= req_i.key;
        nvalid_q <= 1'b0;
        nelem_q  <= '0;
        unique case (req_i.command)
          ibq_pkg::CMD_INSERT: begin
            status_q <= in_range_bad ? ibq_pkg::ST_RANGE :
                        in_present   ? ibq_pkg::ST_DUP : ibq_pkg::ST_OK;
          end
          ibq_pkg::CMD_DELETE,
          ibq_pkg::CMD_QUERY: begin
            status_q <= in_present ? ibq_pkg::ST_OK : ibq_pkg::ST_ABSENT;
          end
          default: status_q <= ibq_pkg::ST_OK;
        endcase
      end
      ibq_pkg::OP_POS: begin
        b_q <= ps_rdata[KW+EW-1:EW];
        s_q <= ps_rdata[EW-1:0];
      end
      ibq_pkg::OP_Q_LEN: idx_q <= AW'(b_q) + AW'(1);
      ibq_pkg::OP_Q_SCAN: begin
        if (!st_o.scan_end && !st_o.scan_hit) begin
          idx_q <= idx_q + AW'(1);
        end
      end
      ibq_pkg::OP_Q_SLOT: begin
        nvalid_q <= 1'b1;
        nelem_q  <= sl_rdata;
      end
      ibq_pkg::OP_RESP: begin
        res_q.status       <= status_q;
        res_q.member       <= present_q[elem_q];
        res_q.next_valid   <= nvalid_q;
        res_q.next_element <= nelem_q;
        res_q.top_element  <= (count_q != '0) ? sl_rdata : '0;
        res_q.top_key      <= (count_q != '0) ? min_q : '0;
        res_q.empty_res    <= (count_q == '0);
        res_q.count        <= count_q;
      end
      default: ;
    endcase
  end

  assign res_o  = res_q;
  assign done_o = strobe_q;

endmodule
`default_nettype wire

/* hdl/indexed_bucket_min_queue.sv */
// Top level of the indexed bucket minimum queue.
// Depends on ibq_pkg, ibq_ctrl and ibq_dp (which holds the ibq_ram instances).
`default_nettype none
// Usage
//   Command channel: drive req_i (command, element, key) with start high; the
//   transfer happens at the rising edge where start is high and busy is low.
//   busy stays high from the cycle after the transfer until the result is out.
//   Result channel: res_o is valid for exactly one cycle, marked by done_o,
//   in the first cycle with busy low again; a new command may transfer then.
//   The receiver cannot stall, so it must take each result as it appears.
// Sequencer steps from transfer to done_o:
//   rejected command (error status or command 3): top-of-queue read, response
//   insert: length read, commit, top-of-queue read, response
//   delete: after the move, the minimum pointer steps past each empty bin
//     (at most NUM_KEYS - 1); no pointer pass when the queue becomes empty
//   query of an element in bin b: the successor is read from bin b when it
//     sits there, or else found in a later bin j by a scan that ends at the
//     allocated bins when there is none; the scan visits one bin a cycle
//   Each RAM (slot, position, length) has one write and one read port.
// Reset clears the presence and bin occupancy bits, the allocated bin count,
//   the minimum pointer and the element count at once; no clearing pass runs,
//   and a command may transfer in the first cycle after reset.
module indexed_bucket_min_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire ibq_pkg::ibq_req_t req_i,
  output ibq_pkg::ibq_res_t      res_o,
  output logic                   done_o
);

  ibq_pkg::ibq_op_e     op;
  ibq_pkg::ibq_status_t st;

  // Sequencer: one op a cycle
  ibq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i(start),
    .st_i   (st),
    .op_o   (op),
    .busy_o (busy)
  );

  // Storage, pointers and result register
  ibq_dp u_dp (
    .clk_i,
    .rst_ni,
    .op_i  (op),
    .req_i,
    .st_o  (st),
    .res_o,
    .done_o
  );

  // The result shows only once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  // Empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.empty_res == (res_o.count == 9'd0)))
    else $error("empty flag disagrees with count");

  // An empty queue reports a zero top
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.empty_res) |-> (res_o.top_key == 6'd0 && res_o.top_element == 8'd0))
    else $error("top reported on empty queue");

  // A transfer always makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("transfer not followed by busy");

  // A query never reports a successor with an error status
  a_next_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.next_valid) |-> (res_o.status == ibq_pkg::ST_OK))
    else $error("successor reported on failed command");

endmodule
`default_nettype wire
